@@ rtl/fft_magnitude_spectrum_unit_defines.svh @@
// Assertion macros for the FFT magnitude spectrum unit.
// Uses the clk and arst_n names of the including module.
`ifndef FFT_MAGNITUDE_SPECTRUM_UNIT_DEFINES_SVH
`define FFT_MAGNITUDE_SPECTRUM_UNIT_DEFINES_SVH

// check cons in the cycle after ante
`define FMSU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// check cons in the same cycle as ante
`define FMSU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`endif

@@ rtl/fmsu_pkg.sv @@
// Shared types, constants and twiddle table generation for the FFT magnitude unit.
// No dependencies.
package fmsu_pkg;

	localparam int FFT_POINTS_DEF = 1024;
	localparam int RING_DEPTH_DEF = 2048;

	localparam int POS_W    = 11;
	localparam int SAMPLE_W = 16;
	localparam int WORD_W   = 28;
	localparam int TW_W     = 19;
	localparam int MAG_W    = 26;
	localparam int SQ_W     = 56;
	localparam int ROOT_W   = 28;
	localparam int TW_MAX   = 4096;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

	typedef struct packed {
		logic mul;
		logic add;
	} bfly_ctl_t;

	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// {cos, sin} of (pi/4) * m / 2^sh, 17 fraction bits each
	function automatic logic [63:0] octant_sincos(int m, int sh);
		logic [63:0] x, x2, term, sum, mm, msk, s64, c64;
		int n;
		mm = 64'(m);
		msk = (64'd1 << sh) - 64'd1;
		x = (PI4_Q62 >> sh) * mm + (((PI4_Q62 & msk) * mm) >> sh);
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		for (n = 1; term != 64'd0 && n < 40; n++) begin
			term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
			sum = n[0] ? sum - term : sum + term;
		end
		s64 = (sum + (64'd1 << 44)) >> 45;
		term = ONE_Q62;
		sum = ONE_Q62;
		for (n = 1; term != 64'd0 && n < 40; n++) begin
			term = mul_q62(term, x2) / 64'((2 * n - 1) * (2 * n));
			sum = n[0] ? sum - term : sum + term;
		end
		c64 = (sum + (64'd1 << 44)) >> 45;
		return {c64[31:0], s64[31:0]};
	endfunction

	// entry k: {re, im} of W^k
	function automatic logic [2*TW_W-1:0] tw_entry(int k, int lg);
		logic [63:0] cs;
		int e, sh, c, s, oc, os;
		e = (1 << lg) / 8;
		sh = lg - 3;
		if (k <= e) begin
			cs = octant_sincos(k, sh); oc = int'(cs[63:32]); os = int'(cs[31:0]);
			c = oc; s = os;
		end else if (k <= 2 * e) begin
			cs = octant_sincos(2 * e - k, sh); oc = int'(cs[63:32]); os = int'(cs[31:0]);
			c = os; s = oc;
		end else if (k <= 3 * e) begin
			cs = octant_sincos(k - 2 * e, sh); oc = int'(cs[63:32]); os = int'(cs[31:0]);
			c = -os; s = oc;
		end else begin
			cs = octant_sincos(4 * e - k, sh); oc = int'(cs[63:32]); os = int'(cs[31:0]);
			c = -oc; s = os;
		end
		return {TW_W'(c), TW_W'(-s)};
	endfunction

	function automatic logic [TW_MAX*2*TW_W-1:0] tw_table(int lg);
		logic [TW_MAX*2*TW_W-1:0] t;
		int k;
		t = '0;
		for (k = 0; k < (1 << (lg - 1)); k++) begin
			t[k*2*TW_W +: 2*TW_W] = tw_entry(k, lg);
		end
		return t;
	endfunction

endpackage

@@ rtl/fmsu_bfly.sv @@
// Radix-2 butterfly datapath: complex multiply, round, add/subtract, saturate.
// Depends on fmsu_pkg.
module fmsu_bfly (
	input  logic                                 clk,
	input  fmsu_pkg::bfly_ctl_t                  ctl,
	input  logic signed [fmsu_pkg::WORD_W-1:0]   a_re,
	input  logic signed [fmsu_pkg::WORD_W-1:0]   a_im,
	input  logic signed [fmsu_pkg::WORD_W-1:0]   b_re,
	input  logic signed [fmsu_pkg::WORD_W-1:0]   b_im,
	input  logic signed [fmsu_pkg::TW_W-1:0]     w_re,
	input  logic signed [fmsu_pkg::TW_W-1:0]     w_im,
	output logic signed [fmsu_pkg::WORD_W-1:0]   p_re,
	output logic signed [fmsu_pkg::WORD_W-1:0]   p_im,
	output logic signed [fmsu_pkg::WORD_W-1:0]   q_re,
	output logic signed [fmsu_pkg::WORD_W-1:0]   q_im
);
	localparam int PW = fmsu_pkg::WORD_W + fmsu_pkg::TW_W;
	localparam int TW = PW + 1 - 17;
	localparam int SW = TW + 1;

	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1;
	logic signed [fmsu_pkg::WORD_W-1:0] a_re_s1, a_im_s1, a_re_s2, a_im_s2;
	logic signed [TW-1:0] t_re_s2, t_im_s2;
	logic signed [PW:0] sum_re, sum_im;

	function automatic logic signed [fmsu_pkg::WORD_W-1:0] sat(logic signed [SW-1:0] v);
		if (v > SW'(2**(fmsu_pkg::WORD_W-1) - 1))
			return {1'b0, {(fmsu_pkg::WORD_W-1){1'b1}}};
		if (v < -SW'(2**(fmsu_pkg::WORD_W-1)))
			return {1'b1, {(fmsu_pkg::WORD_W-1){1'b0}}};
		return fmsu_pkg::WORD_W'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prr_s1  <= b_re * w_re;
			pii_s1  <= b_im * w_im;
			pri_s1  <= b_re * w_im;
			pir_s1  <= b_im * w_re;
			a_re_s1 <= a_re;
			a_im_s1 <= a_im;
		end
		if (ctl.add) begin
			t_re_s2 <= TW'((sum_re + (PW+1)'(65536)) >>> 17);
			t_im_s2 <= TW'((sum_im + (PW+1)'(65536)) >>> 17);
			a_re_s2 <= a_re_s1;
			a_im_s2 <= a_im_s1;
		end
	end

	assign sum_re = (PW+1)'(prr_s1) - (PW+1)'(pii_s1);
	assign sum_im = (PW+1)'(pri_s1) + (PW+1)'(pir_s1);

	assign p_re = sat(SW'(a_re_s2) + SW'(t_re_s2));
	assign p_im = sat(SW'(a_im_s2) + SW'(t_im_s2));
	assign q_re = sat(SW'(a_re_s2) - SW'(t_re_s2));
	assign q_im = sat(SW'(a_im_s2) - SW'(t_im_s2));

endmodule

@@ rtl/fmsu_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Depends on fmsu_pkg.
module fmsu_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fmsu_pkg::SQ_W-1:0]     value,
	output logic                          done,
	output logic [fmsu_pkg::ROOT_W-1:0]   root
);
	localparam int VW = fmsu_pkg::SQ_W + 1;

	logic [VW-1:0] v_q, r_q, bit_q, trial;
	logic          run_q, done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && bit_q[0];
			if (start)
				run_q <= 1'b1;
			else if (bit_q[0])
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= VW'(value);
			r_q   <= '0;
			bit_q <= VW'(1) << (fmsu_pkg::SQ_W - 2);
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[fmsu_pkg::ROOT_W-1:0];

endmodule

@@ rtl/fft_magnitude_spectrum_unit.sv @@
// FFT magnitude spectrum unit: sample ring, work memory, FFT sequencer, magnitude read.
// Depends on fmsu_pkg, fmsu_bfly, fmsu_isqrt and the defines header.
// Write and error items: result 1 cycle after accept, busy stays low.
// Read: result about 32 cycles after accept, set by the bit-serial square root.
// Run: FFT_POINTS + 6 * FFT_POINTS/2 * log2(FFT_POINTS) + 1 cycles, one work memory port.
// Reset clears control only; memories hold garbage until written. The receiver cannot stall.
`include "fft_magnitude_spectrum_unit_defines.svh"

module fft_magnitude_spectrum_unit #(
	parameter int FFT_POINTS = fmsu_pkg::FFT_POINTS_DEF,
	parameter int RING_DEPTH = fmsu_pkg::RING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         opcode,
	input  logic [fmsu_pkg::POS_W-1:0]         position,
	input  logic signed [fmsu_pkg::SAMPLE_W-1:0] sample,
	output logic                               done,
	output logic [fmsu_pkg::MAG_W-1:0]         magnitude,
	output logic                               status
);
	localparam int LG   = $clog2(FFT_POINTS);
	localparam int HALF = FFT_POINTS / 2;
	localparam int JW   = LG - 1;
	localparam int RW   = $clog2(RING_DEPTH);
	localparam int SW   = $clog2(LG + 1);
	localparam int WW   = fmsu_pkg::WORD_W;
	localparam int EW   = 2 * fmsu_pkg::TW_W;
	localparam logic [fmsu_pkg::TW_MAX*EW-1:0] TW_ALL = fmsu_pkg::tw_table(LG);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_LOAD = 11'b00000000010,
		ST_RDQ  = 11'b00000000100,
		ST_RDP  = 11'b00000001000,
		ST_MUL  = 11'b00000010000,
		ST_ADD  = 11'b00000100000,
		ST_WRP  = 11'b00001000000,
		ST_WRQ  = 11'b00010000000,
		ST_SQR  = 11'b00100000000,
		ST_SUM  = 11'b01000000000,
		ST_ROOT = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [fmsu_pkg::SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [2*WW-1:0]               work_mem [FFT_POINTS];

	logic [fmsu_pkg::SAMPLE_W-1:0] ring_rd_q;
	logic [2*WW-1:0]               rd_data_q, b_q, wr_data;
	logic [LG-1:0]                 rd_addr, wr_addr, p_addr, q_addr, low, half_m1;
	logic                          wr_en;
	logic [RW-1:0]                 ring_ptr_q;
	logic [LG-1:0]                 cnt_q, ld_i_s1, half_q;
	logic                          ld_v_s1;
	logic [JW-1:0]                 j_q, k;
	logic [SW-1:0]                 stage_q, twsh_q;
	logic [EW-1:0]                 tw_q;
	logic                          accept, pos_in_ring, pos_in_bins;
	logic                          done_q, status_q;
	logic [fmsu_pkg::MAG_W-1:0]    magnitude_q;
	logic [fmsu_pkg::SQ_W-2:0]     sq_re_q, sq_im_q;
	logic signed [2*WW-1:0]        sq_re, sq_im;
	logic                          root_done;
	logic [fmsu_pkg::ROOT_W-1:0]   root;
	logic signed [WW-1:0]          p_re, p_im, q_re, q_im;
	fmsu_pkg::bfly_ctl_t           bctl;

	function automatic logic [LG-1:0] bit_rev(logic [LG-1:0] v);
		logic [LG-1:0] r;
		for (int i = 0; i < LG; i++) r[i] = v[LG-1-i];
		return r;
	endfunction

	assign accept      = start && (state_q == ST_IDLE);
	assign busy        = (state_q != ST_IDLE);
	assign pos_in_ring = 32'(position) < RING_DEPTH;
	assign pos_in_bins = 32'(position) < HALF;

	assign half_m1 = half_q - LG'(1);
	assign low     = LG'(j_q) & half_m1;
	assign p_addr  = ((LG'(j_q) & ~half_m1) << 1) | low;
	assign q_addr  = p_addr | half_q;
	assign k       = JW'(low << twsh_q);

	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = LG'(position);
			ST_RDQ:  rd_addr = q_addr;
			default: rd_addr = p_addr;
		endcase
		wr_en   = 1'b0;
		wr_addr = p_addr;
		wr_data = {p_re, p_im};
		if (ld_v_s1) begin
			wr_en   = 1'b1;
			wr_addr = bit_rev(ld_i_s1);
			wr_data = {WW'(signed'(ring_rd_q)), {WW{1'b0}}};
		end else if (state_q == ST_WRP) begin
			wr_en = 1'b1;
		end else if (state_q == ST_WRQ) begin
			wr_en   = 1'b1;
			wr_addr = q_addr;
			wr_data = {q_re, q_im};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == fmsu_pkg::OP_WRITE && pos_in_ring)
			ring_mem[RW'(position)] <= sample;
		ring_rd_q <= ring_mem[ring_ptr_q];
		if (wr_en)
			work_mem[wr_addr] <= wr_data;
		rd_data_q <= work_mem[rd_addr];
		tw_q      <= TW_ALL[k*EW +: EW];
		if (state_q == ST_RDP)
			b_q <= rd_data_q;
		if (state_q == ST_SQR) begin
			sq_re_q <= sq_re[fmsu_pkg::SQ_W-2:0];
			sq_im_q <= sq_im[fmsu_pkg::SQ_W-2:0];
		end
		ld_i_s1 <= cnt_q;
	end

	assign sq_re = signed'(rd_data_q[2*WW-1:WW]) * signed'(rd_data_q[2*WW-1:WW]);
	assign sq_im = signed'(rd_data_q[WW-1:0]) * signed'(rd_data_q[WW-1:0]);

	assign bctl.mul = (state_q == ST_MUL);
	assign bctl.add = (state_q == ST_ADD);

	fmsu_bfly u_bfly (
		.clk  (clk),
		.ctl  (bctl),
		.a_re (rd_data_q[2*WW-1:WW]),
		.a_im (rd_data_q[WW-1:0]),
		.b_re (b_q[2*WW-1:WW]),
		.b_im (b_q[WW-1:0]),
		.w_re (tw_q[EW-1:EW/2]),
		.w_im (tw_q[EW/2-1:0]),
		.p_re (p_re),
		.p_im (p_im),
		.q_re (q_re),
		.q_im (q_im)
	);

	fmsu_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SUM),
		.value  (fmsu_pkg::SQ_W'(sq_re_q) + fmsu_pkg::SQ_W'(sq_im_q)),
		.done   (root_done),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			status_q    <= 1'b0;
			magnitude_q <= '0;
			ld_v_s1     <= 1'b0;
			cnt_q       <= '0;
			ring_ptr_q  <= '0;
			j_q         <= '0;
			stage_q     <= '0;
			half_q      <= '0;
			twsh_q      <= '0;
		end else begin
			done_q      <= 1'b0;
			status_q    <= 1'b0;
			magnitude_q <= '0;
			ld_v_s1     <= (state_q == ST_LOAD);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							fmsu_pkg::OP_WRITE: begin
								done_q   <= 1'b1;
								status_q <= !pos_in_ring;
							end
							fmsu_pkg::OP_RUN: begin
								if (pos_in_ring) begin
									state_q    <= ST_LOAD;
									cnt_q      <= '0;
									ring_ptr_q <= RW'(position);
								end else begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end
							end
							fmsu_pkg::OP_READ: begin
								if (pos_in_bins) begin
									state_q <= ST_SQR;
								end else begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= 1'b1;
							end
						endcase
					end
				end
				ST_LOAD: begin
					cnt_q      <= cnt_q + LG'(1);
					ring_ptr_q <= (32'(ring_ptr_q) == RING_DEPTH - 1) ? '0
						: ring_ptr_q + RW'(1);
					if (&cnt_q) begin
						state_q <= ST_RDQ;
						j_q     <= '0;
						stage_q <= SW'(1);
						half_q  <= LG'(1);
						twsh_q  <= SW'(LG - 1);
					end
				end
				ST_RDQ: state_q <= ST_RDP;
				ST_RDP: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_WRP;
				ST_WRP: state_q <= ST_WRQ;
				ST_WRQ: begin
					j_q <= j_q + JW'(1);
					if (&j_q) begin
						if (stage_q == SW'(LG)) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_RDQ;
							stage_q <= stage_q + SW'(1);
							half_q  <= half_q << 1;
							twsh_q  <= twsh_q - SW'(1);
						end
					end else begin
						state_q <= ST_RDQ;
					end
				end
				ST_SQR: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (root_done) begin
						state_q     <= ST_IDLE;
						done_q      <= 1'b1;
						magnitude_q <= (root > fmsu_pkg::ROOT_W'({fmsu_pkg::MAG_W{1'b1}}))
							? {fmsu_pkg::MAG_W{1'b1}} : fmsu_pkg::MAG_W'(root);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign magnitude = magnitude_q;
	assign status    = status_q;

	`FMSU_ASSERT_NEXT(a_write_done, accept && opcode == fmsu_pkg::OP_WRITE, done && !busy)
	`FMSU_ASSERT_NOW(a_err_zero, done && status, magnitude == '0)
	`FMSU_ASSERT_NOW(a_one_writer, ld_v_s1, !(state_q == ST_WRP || state_q == ST_WRQ))
	`FMSU_ASSERT_NEXT(a_run_busy, accept && opcode == fmsu_pkg::OP_RUN && pos_in_ring, busy)

endmodule

@@ tb/fft_magnitude_spectrum_unit_tb.sv @@
// Self-checking testbench for fft_magnitude_spectrum_unit: ring writes, FFT runs, bin reads.
// Holds its own fixed-point FFT predictor; depends on fmsu_pkg and the RTL only.
`timescale 1ns / 1ps

module fft_magnitude_spectrum_unit_tb;
	import fmsu_pkg::*;

	localparam int NPTS  = FFT_POINTS_DEF;
	localparam int RDEP  = RING_DEPTH_DEF;
	localparam int LGN   = $clog2(NPTS);
	localparam int HEAD_SPAN = 16;
	localparam int N_RAND = 300;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam longint WMAX = 134217727;
	localparam longint WMIN = -134217728;
	localparam longint MAGMAX = 67108863;

	typedef struct {
		logic [1:0]  op;
		int          pos;
		int          smp;
		bit          typed;
		int          mag;
		bit          st;
	} stim_row_t;

	typedef struct {
		logic [MAG_W-1:0] mag;
		logic             st;
	} bin_result_t;

	logic clk, arst_n, start, busy, done, status;
	logic [1:0] opcode;
	logic [POS_W-1:0] position;
	logic signed [SAMPLE_W-1:0] sample;
	logic [MAG_W-1:0] magnitude;

	longint ring_smp [RDEP];
	longint spec_re [NPTS];
	longint spec_im [NPTS];
	longint tw_cos [NPTS/2];
	longint tw_nsin [NPTS/2];
	bin_result_t pending_bins [$];
	int mismatches, results_seen, idle_pct, run_count, read_count, write_count;

	fft_magnitude_spectrum_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .position(position), .sample(sample),
		.done(done), .magnitude(magnitude), .status(status)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic void octant(input int m, output longint c, output longint s);
		real ang;
		ang = 3.14159265358979323846 / 4.0 * m / real'(1 << (LGN - 3));
		c = longint'($floor($cos(ang) * 131072.0 + 0.5));
		s = longint'($floor($sin(ang) * 131072.0 + 0.5));
	endfunction

	function automatic void build_twiddles();
		int k, e;
		longint oc, os, c, s;
		e = NPTS / 8;
		for (k = 0; k < NPTS / 2; k++) begin
			if (k <= e) begin
				octant(k, oc, os); c = oc; s = os;
			end else if (k <= 2 * e) begin
				octant(2 * e - k, oc, os); c = os; s = oc;
			end else if (k <= 3 * e) begin
				octant(k - 2 * e, oc, os); c = -os; s = oc;
			end else begin
				octant(4 * e - k, oc, os); c = -oc; s = os;
			end
			tw_cos[k] = c;
			tw_nsin[k] = -s;
		end
	endfunction

	function automatic longint clip28(input longint v);
		return (v > WMAX) ? WMAX : (v < WMIN) ? WMIN : v;
	endfunction

	function automatic void run_transform(input int head);
		int i, d, b, stg, span, half, base, r, k, p, q;
		longint br, bi, ar, ai, tr, ti;
		for (i = 0; i < NPTS; i++) begin
			d = 0;
			for (b = 0; b < LGN; b++)
				d = (d << 1) | ((i >> b) & 1);
			spec_re[d] = ring_smp[(head + i) % RDEP];
			spec_im[d] = 0;
		end
		for (stg = 1; stg <= LGN; stg++) begin
			span = 1 << stg;
			half = span >> 1;
			for (base = 0; base + span <= NPTS; base += span) begin
				for (r = 0; r < half; r++) begin
					k = r << (LGN - stg);
					p = base + r;
					q = p + half;
					br = spec_re[q]; bi = spec_im[q];
					tr = (br * tw_cos[k] - bi * tw_nsin[k] + 65536) >>> 17;
					ti = (br * tw_nsin[k] + bi * tw_cos[k] + 65536) >>> 17;
					ar = spec_re[p]; ai = spec_im[p];
					spec_re[p] = clip28(ar + tr);
					spec_im[p] = clip28(ai + ti);
					spec_re[q] = clip28(ar - tr);
					spec_im[q] = clip28(ai - ti);
				end
			end
		end
	endfunction

	function automatic longint bin_magnitude(input int bin);
		longint unsigned v, rt, bt;
		v = longint'(spec_re[bin] * spec_re[bin]) + longint'(spec_im[bin] * spec_im[bin]);
		rt = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= rt + bt) begin
				v -= rt + bt;
				rt = (rt >> 1) + bt;
			end else begin
				rt >>= 1;
			end
			bt >>= 2;
		end
		return (rt > MAGMAX) ? MAGMAX : longint'(rt);
	endfunction

	function automatic bin_result_t predict_item(input logic [1:0] op, input int pos,
			input int smp);
		bin_result_t res;
		res.mag = '0;
		res.st = 1'b0;
		case (op)
			OP_WRITE: begin
				if (pos < RDEP) begin
					ring_smp[pos] = longint'(16'(smp) ^ 16'h8000) - 32768;
					write_count++;
				end else begin
					res.st = 1'b1;
				end
			end
			OP_RUN: begin
				if (pos < RDEP) begin
					run_transform(pos);
					run_count++;
				end else begin
					res.st = 1'b1;
				end
			end
			OP_READ: begin
				if (pos < NPTS / 2) begin
					res.mag = MAG_W'(bin_magnitude(pos));
					read_count++;
				end else begin
					res.st = 1'b1;
				end
			end
			default: res.st = 1'b1;
		endcase
		return res;
	endfunction

	task automatic send_item(input logic [1:0] op, input int pos, input int smp,
			input bit typed, input int tmag, input bit tst);
		bin_result_t res;
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		position <= POS_W'(pos);
		sample <= SAMPLE_W'(smp);
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		res = predict_item(op, pos, smp);
		if (typed) begin
			res.mag = MAG_W'(tmag);
			res.st = tst;
		end
		pending_bins.push_back(res);
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(5)) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		bin_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_bins.size() == 0) begin
				report("unexpected result", magnitude, 0);
			end else begin
				want = pending_bins.pop_front();
				if (magnitude !== want.mag) report("magnitude", magnitude, want.mag);
				if (status !== want.st) report("status", status, want.st);
			end
		end
	end

	stim_row_t table_rows [] = '{
		'{OP_SPARE, 0,    0,      1'b1, 0, 1'b1},
		'{OP_SPARE, 2047, -1,     1'b1, 0, 1'b1},
		'{OP_WRITE, 0,    -32768, 1'b1, 0, 1'b0},
		'{OP_WRITE, 2047, 32767,  1'b1, 0, 1'b0},
		'{OP_WRITE, 1,    0,      1'b1, 0, 1'b0},
		'{OP_WRITE, 1365, 21845,  1'b1, 0, 1'b0},
		'{OP_RUN,   0,    0,      1'b1, 0, 1'b0},
		'{OP_READ,  0,    0,      1'b0, 0, 1'b0},
		'{OP_READ,  511,  0,      1'b0, 0, 1'b0},
		'{OP_READ,  256,  0,      1'b0, 0, 1'b0},
		'{OP_READ,  512,  0,      1'b1, 0, 1'b1},
		'{OP_READ,  2047, 0,      1'b1, 0, 1'b1},
		'{OP_RUN,   2047, 0,      1'b1, 0, 1'b0},
		'{OP_READ,  0,    0,      1'b0, 0, 1'b0},
		'{OP_READ,  1,    0,      1'b0, 0, 1'b0},
		'{OP_READ,  510,  0,      1'b0, 0, 1'b0},
		'{OP_SPARE, 1024, 32767,  1'b1, 0, 1'b1}
	};

	initial begin
		int i, roll, wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_WRITE;
		position = '0;
		sample = '0;
		idle_pct = 0;
		build_twiddles();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the top of the ring and the first FFT_POINTS entries, so heads
		// from HEAD_SPAN below the top through zero are legal runs
		idle_pct = 26;
		for (i = RDEP - HEAD_SPAN; i < RDEP; i++)
			send_item(OP_WRITE, i, $urandom_range(65535), 1'b0, 0, 1'b0);
		for (i = 0; i < NPTS; i++)
			send_item(OP_WRITE, i, $urandom_range(65535), 1'b0, 0, 1'b0);

		foreach (table_rows[j])
			send_item(table_rows[j].op, table_rows[j].pos, table_rows[j].smp,
				table_rows[j].typed, table_rows[j].mag, table_rows[j].st);

		for (i = 0; i < N_RAND; i++) begin
			idle_pct = (i < N_RAND / 3) ? 26 : (i < 2 * N_RAND / 3) ? 45 : 0;
			if (i == N_RAND / 2) begin
				@(negedge clk);
				start <= 1'b0;
				while (pending_bins.size() != 0) @(posedge clk);
			end
			roll = $urandom_range(999);
			if (roll < 20)
				send_item(OP_RUN, (RDEP - HEAD_SPAN + $urandom_range(HEAD_SPAN)) % RDEP,
					$urandom_range(65535), 1'b0, 0, 1'b0);
			else if (roll < 40)
				send_item(OP_SPARE, $urandom_range(2047), $urandom_range(65535),
					1'b0, 0, 1'b0);
			else if (roll < 480)
				send_item(OP_WRITE, $urandom_range(RDEP - 1), $urandom_range(65535),
					1'b0, 0, 1'b0);
			else if (roll < 900)
				send_item(OP_READ, $urandom_range(NPTS / 2 - 1), $urandom_range(65535),
					1'b0, 0, 1'b0);
			else
				send_item(OP_READ, $urandom_range(2047), $urandom_range(65535),
					1'b0, 0, 1'b0);
		end
		@(negedge clk);
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_bins.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (64) @(posedge clk);
		if (pending_bins.size() != 0)
			report("results never returned", pending_bins.size(), 0);

		$display("covered %0d ring writes, %0d transforms, %0d bin reads, %0d results",
			write_count, run_count, read_count, results_seen);
		$display("error items, three idle phases and a full drain mid-run included");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ fft_magnitude_spectrum_unit.f @@
+incdir+rtl
rtl/fmsu_pkg.sv
rtl/fmsu_bfly.sv
rtl/fmsu_isqrt.sv
rtl/fft_magnitude_spectrum_unit.sv
tb/fft_magnitude_spectrum_unit_tb.sv
